### design/fraction_lowest_terms_defines.svh
// Assertion macros shared by the checker of fraction_lowest_terms.
// No dependencies; take in by `include where assertions are written.
`ifndef FRACTION_LOWEST_TERMS_DEFINES_SVH
`define FRACTION_LOWEST_TERMS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FLT_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/flt_pkg.sv
// Shared types and constants of the fraction reduction block.
// No dependencies.
package flt_pkg;

   localparam int FieldW = 32;

   // divider operand select
   localparam logic [1:0] SEL_GCD = 2'd0;
   localparam logic [1:0] SEL_NUM = 2'd1;
   localparam logic [1:0] SEL_DEN = 2'd2;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_sel;
      logic       gcd_step;
      logic       save_num;
      logic       save_den;
      logic       out_load;
      logic       out_ok;
   } cmd_type;

   typedef struct packed {
      logic den_zero;
      logic b_zero;
      logic div_done;
   } status_type;

endpackage

### design/flt_divider.sv
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit a cycle.
// No package dependencies.
module flt_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CntW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] r_ff, r_in, q_ff, q_in, d_ff, d_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic             fits;

   // remainder stays below divisor, so the shifted value is below twice the divisor
   assign trial = {r_ff, q_ff[WIDTH-1]} - {1'b0, d_ff};
   assign fits  = ~trial[WIDTH];

   always_comb begin
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = '0;
         q_in    = dividend;
         d_in    = divisor;
         cnt_in  = CntW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = fits ? trial[WIDTH-1:0] : {r_ff[WIDTH-2:0], q_ff[WIDTH-1]};
         q_in   = {q_ff[WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

### design/flt_datapath.sv
// Datapath: Euclid pair, operands, signed quotients and the output register.
// Depends on flt_pkg and flt_divider.
module flt_datapath
   import flt_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [FieldW-1:0] req_numerator_in,
   input  logic signed [FieldW-1:0] req_denominator_in,
   output logic signed [FieldW-1:0] rsp_numerator_out,
   output logic signed [FieldW-1:0] rsp_denominator_out,
   output logic                     rsp_reduced_ok,
   output logic                     rsp_overflow
);

   logic [WIDTH-1:0] num_w, den_w, out_num_w, out_den_w;
   logic [WIDTH-1:0] num_ff, den_ff, a_ff, b_ff, qn_ff, qd_ff;
   logic [WIDTH-1:0] out_num_ff, out_den_ff;
   logic             ovf_ff, out_ok_ff, out_ovf_ff;
   logic [WIDTH-1:0] op_n, op_d, quot, rem, rem_s, quot_s;
   logic             div_done, quot_neg, quot_ovf;

   function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? -v : v;
   endfunction

   // field to working width and back
   if (WIDTH <= FieldW) begin : g_narrow
      assign num_w = req_numerator_in[WIDTH-1:0];
      assign den_w = req_denominator_in[WIDTH-1:0];
   end else begin : g_wide
      assign num_w = {{(WIDTH-FieldW){1'b0}}, req_numerator_in};
      assign den_w = {{(WIDTH-FieldW){1'b0}}, req_denominator_in};
   end

   if (WIDTH >= FieldW) begin : g_out_trunc
      assign rsp_numerator_out   = out_num_ff[FieldW-1:0];
      assign rsp_denominator_out = out_den_ff[FieldW-1:0];
   end else begin : g_out_pad
      assign rsp_numerator_out   = {{(FieldW-WIDTH){1'b0}}, out_num_ff};
      assign rsp_denominator_out = {{(FieldW-WIDTH){1'b0}}, out_den_ff};
   end

   always_comb begin
      case (cmd.div_sel)
         SEL_NUM: begin
            op_n     = mag(num_ff);
            op_d     = mag(a_ff);
            quot_neg = num_ff[WIDTH-1] ^ a_ff[WIDTH-1];
         end
         SEL_DEN: begin
            op_n     = mag(den_ff);
            op_d     = mag(a_ff);
            quot_neg = den_ff[WIDTH-1] ^ a_ff[WIDTH-1];
         end
         default: begin
            op_n     = mag(a_ff);
            op_d     = mag(b_ff);
            quot_neg = 1'b0;
         end
      endcase
   end

   flt_divider #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (op_n),
      .divisor   (op_d),
      .done      (div_done),
      .quotient  (quot),
      .remainder (rem)
   );

   // remainder takes the dividend's sign; a quotient wraps only for a positive result
   assign rem_s     = a_ff[WIDTH-1] ? -rem : rem;
   assign quot_s    = quot_neg ? -quot : quot;
   assign quot_ovf  = ~quot_neg & quot[WIDTH-1];
   assign out_num_w = cmd.out_ok ? qn_ff : num_ff;
   assign out_den_w = cmd.out_ok ? qd_ff : den_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= num_w;
         den_ff <= den_w;
         a_ff   <= num_w;
         b_ff   <= den_w;
         ovf_ff <= 1'b0;
      end
      if (cmd.gcd_step) begin
         a_ff <= b_ff;
         b_ff <= rem_s;
      end
      if (cmd.save_num) begin
         qn_ff  <= quot_s;
         ovf_ff <= ovf_ff | quot_ovf;
      end
      if (cmd.save_den) begin
         qd_ff  <= quot_s;
         ovf_ff <= ovf_ff | quot_ovf;
      end
      if (cmd.out_load) begin
         out_num_ff <= out_num_w;
         out_den_ff <= out_den_w;
         out_ok_ff  <= cmd.out_ok;
         out_ovf_ff <= cmd.out_ok & ovf_ff;
      end
   end

   assign rsp_reduced_ok  = out_ok_ff;
   assign rsp_overflow    = out_ovf_ff;

   assign status.den_zero = (den_ff == '0);
   assign status.b_zero   = (b_ff == '0);
   assign status.div_done = div_done;

endmodule

### design/flt_ctrl.sv
// Controller: sequences load, Euclid steps, two final divisions, result handoff.
// Depends on flt_pkg.
module flt_ctrl
   import flt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] IDLE     = 4'd0;
   localparam logic [3:0] CHECK    = 4'd1;
   localparam logic [3:0] GCD_GO   = 4'd2;
   localparam logic [3:0] GCD_WAIT = 4'd3;
   localparam logic [3:0] GCD_TEST = 4'd4;
   localparam logic [3:0] NUM_GO   = 4'd5;
   localparam logic [3:0] NUM_WAIT = 4'd6;
   localparam logic [3:0] DEN_GO   = 4'd7;
   localparam logic [3:0] DEN_WAIT = 4'd8;
   localparam logic [3:0] FINISH   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       ok_ff, ok_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      cmd.div_sel = SEL_GCD;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            ok_in    = ~status.den_zero;
            state_in = status.den_zero ? FINISH : GCD_GO;
         end
         GCD_GO: begin
            cmd.div_start = 1'b1;
            state_in      = GCD_WAIT;
         end
         GCD_WAIT: begin
            if (status.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in     = GCD_TEST;
            end
         end
         GCD_TEST: begin
            state_in = status.b_zero ? NUM_GO : GCD_GO;
         end
         NUM_GO: begin
            cmd.div_sel   = SEL_NUM;
            cmd.div_start = 1'b1;
            state_in      = NUM_WAIT;
         end
         NUM_WAIT: begin
            cmd.div_sel = SEL_NUM;
            if (status.div_done) begin
               cmd.save_num = 1'b1;
               state_in     = DEN_GO;
            end
         end
         DEN_GO: begin
            cmd.div_sel   = SEL_DEN;
            cmd.div_start = 1'b1;
            state_in      = DEN_WAIT;
         end
         DEN_WAIT: begin
            cmd.div_sel = SEL_DEN;
            if (status.div_done) begin
               cmd.save_den = 1'b1;
               state_in     = FINISH;
            end
         end
         FINISH: begin
            // wait for the output register to empty
            cmd.out_ok = ok_ff;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/fraction_lowest_terms.sv
// Top level of the fraction reduction block: controller plus datapath.
// Depends on flt_pkg, flt_ctrl, flt_datapath.
//
//   channel  handshake               payload
//   req      req_valid / req_ready   req_numerator_in, req_denominator_in
//   rsp      rsp_valid / rsp_ready   rsp_numerator_out, rsp_denominator_out,
//                                    rsp_reduced_ok, rsp_overflow
//
// One item at a time. Each Euclid step runs the shared bit-serial divider, as do
// the two final divisions; a zero denominator skips them all and goes straight
// to the result. The result sits in an output register, so the next item is
// taken while it waits. Reset clears control state only.
module fraction_lowest_terms
   import flt_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [FieldW-1:0] req_numerator_in,
   input  logic signed [FieldW-1:0] req_denominator_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [FieldW-1:0] rsp_numerator_out,
   output logic signed [FieldW-1:0] rsp_denominator_out,
   output logic                     rsp_reduced_ok,
   output logic                     rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   flt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   flt_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_numerator_in    (req_numerator_in),
      .req_denominator_in  (req_denominator_in),
      .rsp_numerator_out   (rsp_numerator_out),
      .rsp_denominator_out (rsp_denominator_out),
      .rsp_reduced_ok      (rsp_reduced_ok),
      .rsp_overflow        (rsp_overflow)
   );

endmodule

### design/flt_checker.sv
// Port-level checker for fraction_lowest_terms, bound to the top level.
// Depends on flt_pkg and fraction_lowest_terms_defines.svh.
`include "fraction_lowest_terms_defines.svh"

module flt_checker
   import flt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [FieldW-1:0] rsp_numerator_out,
   input logic signed [FieldW-1:0] rsp_denominator_out,
   input logic                     rsp_reduced_ok,
   input logic                     rsp_overflow
);

   // a stalled result holds
   `FLT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_numerator_out) && $stable(rsp_denominator_out), "rsp changed while stalled")

   // one item at a time: the block is busy right after a transfer in
   `FLT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "req_ready stayed high after a transfer")

   // a zero denominator never reports overflow
   `FLT_ASSERT_IMPLY(a_zero_den_no_ovf, clock, reset, rsp_valid && !rsp_reduced_ok, !rsp_overflow, "overflow without reduction")

   // a reduced denominator is den / gcd and cannot be zero
   `FLT_ASSERT_IMPLY(a_reduced_den_nonzero, clock, reset, rsp_valid && rsp_reduced_ok, rsp_denominator_out != 0, "reduced denominator is zero")

endmodule

bind fraction_lowest_terms flt_checker u_flt_checker (.*);
